/* rtl/swdh_pkg.sv */
`default_nettype none

package swdh_pkg;

  // one swd bit period per step; the phase is the position in the transfer
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_HDR   = 4'd1,
    PH_TRNIN = 4'd2,
    PH_ACK   = 4'd3,
    PH_WTURN = 4'd4,
    PH_RDATA = 4'd5,
    PH_RPAR  = 4'd6,
    PH_RTRN  = 4'd7,
    PH_WTRN  = 4'd8,
    PH_WDATA = 4'd9,
    PH_WPAR  = 4'd10
  } swdh_phase_e;

  localparam logic [2:0] ACK_OK   = 3'd1;
  localparam logic [2:0] ACK_WAIT = 3'd2;

  // request bit that selects a read
  localparam int unsigned REQ_RNW_BIT = 1;

  localparam logic [2:0] HDR_LAST  = 3'd7;
  localparam logic [4:0] ACK_LAST  = 5'd2;
  localparam logic [4:0] WORD_LAST = 5'd31;

  typedef struct packed {
    logic        clock_pulse;
    logic        swdio_out;
    logic        swdio_drive;
    logic        busy;
    logic        done;
    logic [2:0]  ack;
    logic [31:0] read_data;
    logic        parity_error;
  } swdh_result_t;

  // start 1, request, parity, stop 0, park 1 (sent lsb first)
  function automatic logic [7:0] swdh_header(input logic [3:0] req);
    swdh_header = {1'b1, 1'b0, ^req, req, 1'b1};
  endfunction

endpackage

`default_nettype wire

/* rtl/swd_host_transfer.sv */
`default_nettype none

// swd host transfer engine. each input item is one swd bit period: op 1 starts
// a transfer (header, turnaround, 3-bit ack, then 32 data bits plus parity for
// a read or a write, with retries on wait up to retry_limit attempts), op 0 is
// a plain tick. every item gives exactly one result item describing that bit
// period: whether swclk pulses, the swdio level and drive enable, busy/done,
// the last ack, the last good read word and the read parity error flag. a start
// while busy acts as a tick. the block takes one item per clock cycle while
// not stalled; an item passes an input register, one pass of the bit-period
// logic against the transfer state, and a result register, where its result
// waits until the output is not stalled. the input side stalls only while
// the result register is full and held. retry_limit (reset 1) is written
// through cfg_we_i / cfg_wdata_i and must only change while no transfer
// runs.
module swd_host_transfer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // input item channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [3:0]  req_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic        swdio_in_i,
  // result item channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             clock_pulse_o,
  output logic             swdio_out_o,
  output logic             swdio_drive_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic [2:0]       ack_o,
  output logic [31:0]      read_data_o,
  output logic             parity_error_o
);
  import swdh_pkg::*;

  logic [7:0]   retry_q;
  logic         in_valid_q;
  logic         op_q;
  logic [3:0]   req_q;
  logic [31:0]  wdata_q;
  logic         swdio_q;
  logic         out_valid_q;
  swdh_result_t res_q;
  swdh_result_t res_d;
  logic         advance;
  logic         step;

  // retry limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q <= 8'd1;
    end else if (cfg_we_i) begin
      retry_q <= cfg_wdata_i;
    end
  end

  // the result register frees up when it is empty or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q    <= op_i;
      req_q   <= req_i;
      wdata_q <= write_data_i;
      swdio_q <= swdio_in_i;
    end
  end

  // one bit period of the transfer; state moves only when an item is stepped
  swdh_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .op_i          (op_q),
    .req_i         (req_q),
    .write_data_i  (wdata_q),
    .swdio_in_i    (swdio_q),
    .retry_limit_i (retry_q),
    .res_o         (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign clock_pulse_o  = res_q.clock_pulse;
  assign swdio_out_o    = res_q.swdio_out;
  assign swdio_drive_o  = res_q.swdio_drive;
  assign busy_res_o     = res_q.busy;
  assign done_res_o     = res_q.done;
  assign ack_o          = res_q.ack;
  assign read_data_o    = res_q.read_data;
  assign parity_error_o = res_q.parity_error;

`ifndef SYNTHESIS
  // the input side only stalls while it holds an item behind a full result
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a held item");

  // a finishing period never reports the transfer as still running
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(done_res_o && busy_res_o))
    else $error("done and busy in the same item");

  // no swclk pulse in a period that neither runs nor ends a transfer
  a_idle_no_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !busy_res_o && !done_res_o) |-> !clock_pulse_o)
    else $error("clock pulse while idle");

  // a parity error is only reported once the transfer is over
  a_perr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && parity_error_o) |-> !busy_res_o)
    else $error("parity error while busy");

  // the retry limit is only written while no item is in flight
  a_cfg_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> (!in_valid_q && !out_valid_q))
    else $error("retry limit written with an item in flight");
`endif

endmodule

`default_nettype wire

/* rtl/swdh_engine.sv */
`default_nettype none

module swdh_engine (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic                  op_i,
  input  wire logic [3:0]            req_i,
  input  wire logic [31:0]           write_data_i,
  input  wire logic                  swdio_in_i,
  input  wire logic [7:0]            retry_limit_i,
  output swdh_pkg::swdh_result_t     res_o
);
  import swdh_pkg::*;

  swdh_phase_e phase_q, phase_d;
  logic [4:0]  bit_cnt_q, bit_cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [3:0]  req_q, req_d;
  logic [31:0] wdata_q, wdata_d;
  logic [2:0]  ack_q, ack_d;
  logic [7:0]  attempts_q, attempts_d;
  logic        par_q, par_d;
  logic [31:0] rdata_q, rdata_d;
  logic        drive_q, drive_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= '0;
      shift_q    <= '0;
      req_q      <= '0;
      wdata_q    <= '0;
      ack_q      <= '0;
      attempts_q <= '0;
      par_q      <= 1'b0;
      rdata_q    <= '0;
      drive_q    <= 1'b1;
    end else if (step_i) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      req_q      <= req_d;
      wdata_q    <= wdata_d;
      ack_q      <= ack_d;
      attempts_q <= attempts_d;
      par_q      <= par_d;
      rdata_q    <= rdata_d;
      drive_q    <= drive_d;
    end
  end

  always_comb begin
    logic       clk;
    logic       lvl;
    logic       drv;
    logic       done;
    logic [2:0] ack_new;
    logic [7:0] att_dec;

    clk        = 1'b0;
    lvl        = 1'b1;
    drv        = drive_q;
    done       = 1'b0;
    ack_new    = ack_q;
    att_dec    = attempts_q;
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    req_d      = req_q;
    wdata_d    = wdata_q;
    ack_d      = ack_q;
    attempts_d = attempts_q;
    par_d      = par_q;
    rdata_d    = rdata_q;
    drive_d    = drive_q;

    unique case (phase_q)
      PH_HDR: begin
        clk = 1'b1;
        drv = 1'b1;
        lvl = shift_q[bit_cnt_q];
        if (bit_cnt_q[2:0] == HDR_LAST) begin
          bit_cnt_d = '0;
          phase_d   = PH_TRNIN;
        end else begin
          bit_cnt_d = bit_cnt_q + 5'd1;
        end
      end
      PH_TRNIN: begin
        clk       = 1'b1;
        drv       = 1'b0;
        drive_d   = 1'b0;
        bit_cnt_d = '0;
        phase_d   = PH_ACK;
      end
      PH_ACK: begin
        clk = 1'b1;
        drv = 1'b0;
        if (bit_cnt_q[1:0] != 2'd3) begin
          ack_new[bit_cnt_q[1:0]] = ack_q[bit_cnt_q[1:0]] | swdio_in_i;
        end
        ack_d = ack_new;
        if (bit_cnt_q == ACK_LAST) begin
          bit_cnt_d = '0;
          if (ack_new == ACK_WAIT) begin
            phase_d = PH_WTURN;
          end else if (ack_new == ACK_OK) begin
            if (req_q[REQ_RNW_BIT]) begin
              shift_d = '0;
              par_d   = 1'b0;
              phase_d = PH_RDATA;
            end else begin
              phase_d = PH_WTRN;
            end
          end else begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end else begin
          bit_cnt_d = bit_cnt_q + 5'd1;
        end
      end
      PH_WTURN: begin
        clk     = 1'b1;
        drv     = 1'b1;
        drive_d = 1'b1;
        if (attempts_q != 8'd0) begin
          att_dec = attempts_q - 8'd1;
        end
        attempts_d = att_dec;
        if (att_dec == 8'd0) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end else begin
          shift_d   = {24'd0, swdh_header(req_q)};
          bit_cnt_d = '0;
          ack_d     = '0;
          phase_d   = PH_HDR;
        end
      end
      PH_RDATA: begin
        clk = 1'b1;
        drv = 1'b0;
        shift_d[bit_cnt_q] = shift_q[bit_cnt_q] | swdio_in_i;
        par_d = par_q ^ swdio_in_i;
        if (bit_cnt_q == WORD_LAST) begin
          bit_cnt_d = '0;
          phase_d   = PH_RPAR;
        end else begin
          bit_cnt_d = bit_cnt_q + 5'd1;
        end
      end
      PH_RPAR: begin
        clk   = 1'b1;
        drv   = 1'b0;
        par_d = par_q ^ swdio_in_i;
        if (!(par_q ^ swdio_in_i)) begin
          rdata_d = shift_q;
        end
        phase_d = PH_RTRN;
      end
      PH_RTRN: begin
        clk     = 1'b1;
        drv     = 1'b1;
        drive_d = 1'b1;
        phase_d = PH_IDLE;
        done    = 1'b1;
      end
      PH_WTRN: begin
        clk       = 1'b1;
        drv       = 1'b1;
        drive_d   = 1'b1;
        shift_d   = wdata_q;
        par_d     = 1'b0;
        bit_cnt_d = '0;
        phase_d   = PH_WDATA;
      end
      PH_WDATA: begin
        clk     = 1'b1;
        drv     = 1'b1;
        lvl     = shift_q[0];
        par_d   = par_q ^ shift_q[0];
        shift_d = {1'b0, shift_q[31:1]};
        if (bit_cnt_q == WORD_LAST) begin
          bit_cnt_d = '0;
          phase_d   = PH_WPAR;
        end else begin
          bit_cnt_d = bit_cnt_q + 5'd1;
        end
      end
      PH_WPAR: begin
        clk     = 1'b1;
        drv     = 1'b1;
        lvl     = par_q;
        par_d   = 1'b0;
        phase_d = PH_IDLE;
        done    = 1'b1;
      end
      default: begin
        // idle: a start takes the line and, with a nonzero retry limit, loads the header
        phase_d = PH_IDLE;
        if (op_i) begin
          req_d   = req_i;
          wdata_d = write_data_i;
          par_d   = 1'b0;
          ack_d   = '0;
          drive_d = 1'b1;
          drv     = 1'b1;
          if (retry_limit_i == 8'd0) begin
            done = 1'b1;
          end else begin
            attempts_d = retry_limit_i;
            shift_d    = {24'd0, swdh_header(req_i)};
            bit_cnt_d  = '0;
            phase_d    = PH_HDR;
          end
        end
      end
    endcase

    res_o.clock_pulse  = clk;
    res_o.swdio_out    = lvl;
    res_o.swdio_drive  = drv;
    res_o.busy         = (phase_d != PH_IDLE);
    res_o.done         = done;
    res_o.ack          = ack_d;
    res_o.read_data    = rdata_d;
    res_o.parity_error = (phase_d == PH_IDLE) ? par_d : 1'b0;
  end

endmodule

`default_nettype wire
